// ===== rtl/bd_pkg.sv =====
package bd_pkg;

	// Default widths
	localparam int SAMPLE_BITS_DEF = 16;
	localparam int COEFF_BITS_DEF  = 16;

	// Fixed field widths
	localparam int TRIG_BITS  = 15;
	localparam int ENV_BITS   = 15;
	localparam int STAGE_BITS = 32;

	// Register reset values, Q0.16 and Q0.15
	localparam int SMOOTH_RESET  = 1287;
	localparam int RELEASE_RESET = 65468;
	localparam int TRIGGER_RESET = 983;

	// Register indexes
	localparam logic [1:0] REG_SMOOTH  = 2'd0;
	localparam logic [1:0] REG_RELEASE = 2'd1;
	localparam logic [1:0] REG_TRIGGER = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_ADD,
		ST_ENV,
		ST_TRIG
	} state_t;

	typedef enum logic [1:0] {
		PH_FIRST,
		PH_SECOND,
		PH_PEAK
	} phase_t;

endpackage

// ===== rtl/bd_mac.sv =====
// Shared multiply/round/accumulate: res = sat_q31(base + rnd(coef * diff)).
// The product is registered; rounding, add and saturation follow combinationally.
module bd_mac #(
	parameter int COEFF_BITS = bd_pkg::COEFF_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 mul_en,
	input  logic signed [bd_pkg::STAGE_BITS:0]   diff,
	input  logic        [COEFF_BITS-1:0]         coef,
	input  logic signed [bd_pkg::STAGE_BITS-1:0] base,
	output logic signed [bd_pkg::STAGE_BITS-1:0] res
);

	localparam int PW = bd_pkg::STAGE_BITS + 2 + COEFF_BITS;
	localparam int RW = PW - COEFF_BITS;
	localparam int SW = bd_pkg::STAGE_BITS + 3;
	localparam logic signed [SW-1:0] SAT_MAX = SW'(64'sd2147483647);
	localparam logic signed [SW-1:0] SAT_MIN = SW'(-64'sd2147483648);

	logic signed [COEFF_BITS:0] coef_s;
	logic signed [PW-1:0]       prod_s1;
	logic signed [PW-1:0]       rnd_sum;
	logic signed [RW-1:0]       rounded;
	logic signed [SW-1:0]       sum;

	assign coef_s = $signed({1'b0, coef});

	always_ff @(posedge clk) begin
		if (mul_en) begin
			prod_s1 <= diff * coef_s;
		end
	end

	// Round to nearest, ties up: add half an LSB, then floor shift.
	assign rnd_sum = prod_s1 + (PW'(1) <<< (COEFF_BITS - 1));
	assign rounded = rnd_sum[PW-1:COEFF_BITS];
	assign sum     = SW'(base) + SW'(rounded);

	always_comb begin
		if (sum > SAT_MAX) begin
			res = SAT_MAX[bd_pkg::STAGE_BITS-1:0];
		end else if (sum < SAT_MIN) begin
			res = SAT_MIN[bd_pkg::STAGE_BITS-1:0];
		end else begin
			res = sum[bd_pkg::STAGE_BITS-1:0];
		end
	end

endmodule

// ===== rtl/beat_detector_unit.sv =====
// Each request runs MUL, ADD, MUL, ADD, ENV, then MUL, ADD unless the envelope attacks, then TRIG;
// a new one is taken only back in IDLE. Each sample passes through the single multiply/accumulate
// unit three times (two lowpass stages, release), twice on attack, when release is skipped.
// A new request is taken while the previous result still waits in the output register.
// Reset (arst_n low, asynchronous) clears both filter stages, the envelope and the
// trigger, and returns the coefficient and level registers to their defaults.
module beat_detector_unit #(
	parameter int SAMPLE_BITS = bd_pkg::SAMPLE_BITS_DEF,
	parameter int COEFF_BITS  = bd_pkg::COEFF_BITS_DEF,
	localparam int S_TDATA_W  = ((SAMPLE_BITS + 7) / 8) * 8,
	localparam int M_FIELDS   = 2 + bd_pkg::ENV_BITS,
	localparam int M_TDATA_W  = ((M_FIELDS + 7) / 8) * 8,
	localparam int CFG_W      = (COEFF_BITS > bd_pkg::TRIG_BITS) ? COEFF_BITS
	                                                              : bd_pkg::TRIG_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [S_TDATA_W-1:0]  s_tdata,  // [SAMPLE_BITS-1:0] sample
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [M_TDATA_W-1:0]  m_tdata,  // [0] beat_pulse, [1] beat_active, [16:2] envelope
	input  logic                  cfg_we,
	input  logic [1:0]            cfg_index,
	input  logic [CFG_W-1:0]      cfg_data
);

	localparam int XSHIFT    = bd_pkg::STAGE_BITS - SAMPLE_BITS;
	localparam int SB        = bd_pkg::STAGE_BITS;
	localparam logic signed [SB-1:0] STAGE_MIN = SB'(-64'sd2147483648);

	// Configuration registers
	logic [COEFF_BITS-1:0]        smooth_q;
	logic [COEFF_BITS-1:0]        release_q;
	logic [bd_pkg::TRIG_BITS-1:0] trigger_q;

	// Architectural state
	logic signed [SB-1:0] first_q;
	logic signed [SB-1:0] second_q;
	logic [SB-2:0]        peak_q;
	logic                 trig_q;

	// Sequencer and shared-unit operands
	bd_pkg::state_t       state_q, state_d;
	bd_pkg::phase_t       phase_q;
	logic signed [SB:0]   diff_q;
	logic signed [SB-1:0] base_q;
	logic [COEFF_BITS-1:0] coef_q;
	logic signed [SB-1:0] mac_res;

	// Output register
	logic                 m_tvalid_q;
	logic [M_TDATA_W-1:0] m_tdata_q;

	// Per-sample helpers
	logic signed [SB-1:0] sample_x;
	logic [SB-2:0]        env_abs;
	logic [SB-2:0]        thr;
	logic [SB+2:0]        peak_x5;
	logic [SB+2:0]        thr_x4;
	logic                 trig_next;
	logic                 out_free;

	assign s_tready = (state_q == bd_pkg::ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign out_free = !m_tvalid_q || m_tready;

	// Align the sample to Q1.31.
	assign sample_x = SB'($signed(s_tdata[SAMPLE_BITS-1:0])) <<< XSHIFT;

	// Magnitude of the second stage; the most negative value saturates.
	always_comb begin
		if (!second_q[SB-1]) begin
			env_abs = second_q[SB-2:0];
		end else if (second_q == STAGE_MIN) begin
			env_abs = {(SB-1){1'b1}};
		end else begin
			env_abs = (SB-1)'(-second_q);
		end
	end

	// Schmitt trigger: set above the level, clear below 0.8 of it.
	assign thr     = {trigger_q, 16'b0};
	assign peak_x5 = (SB+3)'(peak_q) + ((SB+3)'(peak_q) << 2);
	assign thr_x4  = (SB+3)'(thr) << 2;
	assign trig_next = trig_q ? !(peak_x5 < thr_x4) : (peak_q > thr);

	bd_mac #(
		.COEFF_BITS (COEFF_BITS)
	) u_mac (
		.clk    (clk),
		.mul_en (state_q == bd_pkg::ST_MUL),
		.diff   (diff_q),
		.coef   (coef_q),
		.base   (base_q),
		.res    (mac_res)
	);

	// Configuration writes; unknown indexes drop.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smooth_q  <= COEFF_BITS'(bd_pkg::SMOOTH_RESET);
			release_q <= COEFF_BITS'(bd_pkg::RELEASE_RESET);
			trigger_q <= bd_pkg::TRIG_BITS'(bd_pkg::TRIGGER_RESET);
		end else if (cfg_we) begin
			case (cfg_index)
				bd_pkg::REG_SMOOTH:  smooth_q  <= cfg_data[COEFF_BITS-1:0];
				bd_pkg::REG_RELEASE: release_q <= cfg_data[COEFF_BITS-1:0];
				bd_pkg::REG_TRIGGER: trigger_q <= cfg_data[bd_pkg::TRIG_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bd_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			bd_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					state_d = bd_pkg::ST_MUL;
				end
			end
			bd_pkg::ST_MUL: state_d = bd_pkg::ST_ADD;
			bd_pkg::ST_ADD: begin
				case (phase_q)
					bd_pkg::PH_FIRST:  state_d = bd_pkg::ST_MUL;
					bd_pkg::PH_SECOND: state_d = bd_pkg::ST_ENV;
					default:           state_d = bd_pkg::ST_TRIG;
				endcase
			end
			bd_pkg::ST_ENV: begin
				// Instant attack skips the release pass.
				if (env_abs > peak_q) begin
					state_d = bd_pkg::ST_TRIG;
				end else begin
					state_d = bd_pkg::ST_MUL;
				end
			end
			bd_pkg::ST_TRIG: begin
				// Hold until the output register can take the result.
				if (out_free) begin
					state_d = bd_pkg::ST_IDLE;
				end
			end
			default: state_d = bd_pkg::ST_IDLE;
		endcase
	end

	// Filter, envelope and trigger state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q  <= '0;
			second_q <= '0;
			peak_q   <= '0;
			trig_q   <= 1'b0;
			phase_q  <= bd_pkg::PH_FIRST;
		end else begin
			case (state_q)
				bd_pkg::ST_IDLE: phase_q <= bd_pkg::PH_FIRST;
				bd_pkg::ST_ADD: begin
					case (phase_q)
						bd_pkg::PH_FIRST: begin
							first_q <= mac_res;
							phase_q <= bd_pkg::PH_SECOND;
						end
						bd_pkg::PH_SECOND: second_q <= mac_res;
						default:           peak_q   <= mac_res[SB-2:0];
					endcase
				end
				bd_pkg::ST_ENV: begin
					if (env_abs > peak_q) begin
						peak_q <= env_abs;
					end else begin
						phase_q <= bd_pkg::PH_PEAK;
					end
				end
				bd_pkg::ST_TRIG: begin
					if (out_free) begin
						trig_q <= trig_next;
					end
				end
				default: ;
			endcase
		end
	end

	// Operands of the shared unit; release pass: e + rnd((peak - e) * r).
	always_ff @(posedge clk) begin
		case (state_q)
			bd_pkg::ST_IDLE: begin
				diff_q <= (SB+1)'(sample_x) - (SB+1)'(first_q);
				base_q <= first_q;
				coef_q <= smooth_q;
			end
			bd_pkg::ST_ADD: begin
				diff_q <= (SB+1)'(mac_res) - (SB+1)'(second_q);
				base_q <= second_q;
			end
			bd_pkg::ST_ENV: begin
				diff_q <= $signed({2'b00, peak_q}) - $signed({2'b00, env_abs});
				base_q <= $signed({1'b0, env_abs});
				coef_q <= release_q;
			end
			default: ;
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == bd_pkg::ST_TRIG && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == bd_pkg::ST_TRIG && out_free) begin
			m_tdata_q <= M_TDATA_W'({peak_q[SB-2:16], trig_next, trig_next & !trig_q});
		end
	end

	// A result appears only out of the trigger step.
	a_valid_from_trig: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(state_q == bd_pkg::ST_TRIG))
		else $error("result raised outside the trigger step");

	// The release pass never raises the envelope.
	a_release_decays: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bd_pkg::ST_ADD && phase_q == bd_pkg::PH_PEAK) |=>
		(peak_q <= $past(peak_q)))
		else $error("release raised the envelope");

	// A pulse implies the trigger is on.
	a_pulse_active: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q |-> (!m_tdata_q[0] || m_tdata_q[1]))
		else $error("pulse without active trigger");

endmodule
